// ----- sv/queue_with_middle_insert_core_defines.svh -----
// Assertion macros for the queue core.
`ifndef QUEUE_WITH_MIDDLE_INSERT_CORE_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_INSERT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define QMI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define QMI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QMI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QMI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/qmi_pkg.sv -----
`default_nettype none
package qmi_pkg;

	localparam int QMI_CAPACITY = 64;
	localparam int DATA_W       = 32;
	localparam int MODE_W       = 2;
	localparam int OCC_W        = 7;

	localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_MID  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POP       = 2'd2;
	localparam logic [MODE_W-1:0] MODE_POP_ALT   = 2'd3;

	typedef enum logic [1:0] {
		RES_PUSH_OK   = 2'd0,
		RES_POPPED    = 2'd1,
		RES_POP_EMPTY = 2'd2,
		RES_PUSH_FULL = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH_TAIL,
		OP_PUSH_MID,
		OP_POP
	} op_t;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic load;
		op_t  op;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/qmi_ifs.sv -----
`default_nettype none
interface qmi_req_if import qmi_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [DATA_W-1:0] item_value;

	modport source (output valid, output mode, output item_value, input ready);
	modport sink (input valid, input mode, input item_value, output ready);
endinterface

interface qmi_rsp_if import qmi_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] popped_value;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output popped_value, output occupancy,
		input ready);
	modport sink (input valid, input status, input popped_value, input occupancy,
		output ready);
endinterface
`default_nettype wire

// ----- sv/qmi_ctrl.sv -----
`default_nettype none
module qmi_ctrl import qmi_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic [MODE_W-1:0] req_mode,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire dp_stat_t          stat,
	output cmd_t                   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd       = '{load: 1'b0, op: OP_NONE, res: RES_PUSH_OK};
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_HOLD: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (req_valid && req_ready) begin
			cmd.load = 1'b1;
			state_d  = S_HOLD;
			unique case (req_mode) inside
				MODE_POP, MODE_POP_ALT: begin
					if (stat.empty) begin
						cmd.res = RES_POP_EMPTY;
					end else begin
						cmd.op  = OP_POP;
						cmd.res = RES_POPPED;
					end
				end
				MODE_PUSH_MID: begin
					if (stat.full) begin
						cmd.res = RES_PUSH_FULL;
					end else begin
						cmd.op = OP_PUSH_MID;
					end
				end
				MODE_PUSH_TAIL: begin
					if (stat.full) begin
						cmd.res = RES_PUSH_FULL;
					end else begin
						cmd.op = OP_PUSH_TAIL;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/qmi_dp.sv -----
`default_nettype none
`include "queue_with_middle_insert_core_defines.svh"
module qmi_dp import qmi_pkg::*; #(
	parameter int CAPACITY = QMI_CAPACITY
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	input  wire logic signed [DATA_W-1:0] item_value,
	output dp_stat_t                      stat,
	output res_t                          res_status,
	output logic signed [DATA_W-1:0]      res_popped,
	output logic [OCC_W-1:0]              res_occ
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0]            count_q;
	logic [CW:0]              cnt_inc;
	logic [CW-1:0]            pos;
	logic signed [DATA_W-1:0] cell_q [CAPACITY];
	res_t                     res_status_q;
	logic signed [DATA_W-1:0] res_popped_q;
	logic [OCC_W-1:0]         res_occ_q;
	logic [CW-1:0]            count_d;
	logic                     pop_op;
	logic                     push_op;

	assign cnt_inc = {1'b0, count_q} + 1'b1;
	assign pos     = (cmd.op == OP_PUSH_MID) ? cnt_inc[CW:1] : count_q;
	assign pop_op  = cmd.load && (cmd.op == OP_POP);
	assign push_op = cmd.load && (cmd.op == OP_PUSH_TAIL || cmd.op == OP_PUSH_MID);

	always_comb begin
		count_d = count_q;
		case (cmd.op) inside
			OP_POP:                    count_d = count_q - 1'b1;
			OP_PUSH_TAIL, OP_PUSH_MID: count_d = cnt_inc[CW-1:0];
			default:                   count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_d;
		end
	end

	// shift cells: pop moves every cell one toward the front,
	// push opens a hole at pos and moves the tail one toward the back
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic signed [DATA_W-1:0] from_back;
		logic signed [DATA_W-1:0] from_front;

		if (i == CAPACITY - 1) begin : g_last
			assign from_back = cell_q[i];
		end else begin : g_mid
			assign from_back = cell_q[i+1];
		end
		if (i == 0) begin : g_first
			assign from_front = cell_q[i];
		end else begin : g_rest
			assign from_front = cell_q[i-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.load) begin
				case (cmd.op) inside
					OP_POP: begin
						cell_q[i] <= from_back;
					end
					OP_PUSH_TAIL, OP_PUSH_MID: begin
						if (IDX == pos) begin
							cell_q[i] <= item_value;
						end else if (IDX > pos && IDX <= count_q) begin
							cell_q[i] <= from_front;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= cmd.res;
			res_popped_q <= (cmd.op == OP_POP) ? cell_q[0] : '0;
			res_occ_q    <= OCC_W'(count_d);
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q >= CAP_C);
	assign res_status = res_status_q;
	assign res_popped = res_popped_q;
	assign res_occ    = res_occ_q;

	`QMI_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, count_q <= CAP_C)
	`QMI_ASSERT_NXT(a_pop_dec, clk, arst_n, pop_op, count_q == $past(count_q) - 1'b1)
	`QMI_ASSERT_NXT(a_push_inc, clk, arst_n, push_op, count_q == $past(count_q) + 1'b1)
	`QMI_ASSERT_NXT(a_occ_cnt, clk, arst_n, cmd.load, res_occ_q == OCC_W'(count_q))

endmodule
`default_nettype wire

// ----- sv/queue_with_middle_insert_core.sv -----
// Bounded queue of signed 32-bit values with push at back, push into the
// middle and pop from the front.
// req channel: one beat per request (mode, item_value).
// rsp channel: exactly one beat per request (status, popped_value, occupancy).
// A middle push with k stored entries lands at position ceil(k/2), front = 0.
// Pop on empty and push on full report their status and leave the store alone.
// Latency: the result beat is valid the cycle after the request beat.
// Throughput: one request per cycle while rsp.ready is high; the shift-cell array
// updates every cell for a request at once and the result register lets the next
// request in while the current result is taken.
// Receiver stall: the result register holds its beat and req.ready drops
// until rsp.ready returns.
// Reset: the queue is empty and no result is pending; cell contents are
// not cleared and are never read before being written.
`default_nettype none
module queue_with_middle_insert_core import qmi_pkg::*; #(
	parameter int CAPACITY = QMI_CAPACITY
) (
	input wire logic clk,
	input wire logic arst_n,
	qmi_req_if.sink   req,
	qmi_rsp_if.source rsp
);

	cmd_t     cmd;
	dp_stat_t stat;
	res_t     res_status;

	qmi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	qmi_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_value (req.item_value),
		.stat       (stat),
		.res_status (res_status),
		.res_popped (rsp.popped_value),
		.res_occ    (rsp.occupancy)
	);

	assign rsp.status = res_status;

endmodule
`default_nettype wire
